/* sv/hbwd_pkg.sv */
// Package for the heartbeat watchdog table: sizes, codes, FSM states,
// result and divider handshake types. No dependencies.
package hbwd_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W = $clog2(DATA_W);
  localparam logic [DATA_W-1:0] INTERVAL_MAX = 32'hFFFF_FFFF;
  localparam int unsigned IN_W = 168;
  localparam int unsigned OUT_W = 72;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SET   = 3'd3,
    CMD_REPLY = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_POLL = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LOC  = 3'd1,
    ST_BAD_TMO  = 3'd2,
    ST_BAD_IVL  = 3'd3,
    ST_BAD_ID   = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_WAIT = 2'd1,
    PH_OK   = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TK_SCAN,
    S_TK_PROC,
    S_TK_END,
    S_SA_LOC,
    S_SA_DIV_GO,
    S_SA_DIV_WAIT,
    S_SA_COMMIT,
    S_SA_FIN,
    S_RT_GO,
    S_RT_WAIT,
    S_RT_END,
    S_SET_SCAN,
    S_FIND,
    S_RP_FIN,
    S_EMIT
  } state_e;

  typedef struct packed {
    kind_e             kind;
    status_e           status;
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] loc;
    logic              last;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

  function automatic res_t mk_res(kind_e k, status_e s, logic [DATA_W-1:0] id,
                                  logic [DATA_W-1:0] loc, logic last);
    res_t r;
    r.kind = k;
    r.status = s;
    r.id = id;
    r.loc = loc;
    r.last = last;
    return r;
  endfunction

endpackage

/* sv/heartbeat_watchdog_table.sv */
// Heartbeat watchdog table top level: command sequencer, slot storage and
// result register. Depends on hbwd_pkg and hbwd_div.
//
// Usage: commands enter on s_axis (tuser = cmd, tdata = host, location_key,
// interval, reply_timeout, entry_ref, alive). Each command produces zero or
// more poll or failure beats and then one done beat with tlast high on
// m_axis (tuser = kind, tdata = status, result_id, result_location).
// cfg_valid/cfg_data write local_host; the port is always ready.
// One command is worked at a time; s_axis_tready is high only when idle.
// Stop and reply walk the slots once. A tick makes one scan of the slots per
// valid slot plus one. Start and set interval walk the slots and run the
// shared serial divider once per valid slot for the retune; a start with an
// interval below the tick interval runs it once more per valid slot for the
// interval check.
// The next command is taken while the last done beat still waits.
// A stalled receiver holds the sequencer at its next beat; nothing drops.
// Reset empties the table, sets the tick interval to its maximum and the
// id counter and local_host to zero; no clearing pass is needed.
module heartbeat_watchdog_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hbwd_pkg::DATA_W-1:0]   cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // host, location_key, interval, reply_timeout, entry_ref, alive, pad
  input  logic [hbwd_pkg::IN_W-1:0]     s_axis_tdata,
  // cmd
  input  logic [2:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status, result_id, result_location, pad
  output logic [hbwd_pkg::OUT_W-1:0]    m_axis_tdata,
  // kind
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);
  import hbwd_pkg::*;

  state_e            state_q, state_d, ret_q, ret_d;
  logic [DATA_W-1:0] local_host_q;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [DATA_W-1:0] sid_q [ENTRIES];
  logic [DATA_W-1:0] sid_d [ENTRIES];
  logic [DATA_W-1:0] sloc_q [ENTRIES];
  logic [DATA_W-1:0] sloc_d [ENTRIES];
  logic [DATA_W-1:0] sivl_q [ENTRIES];
  logic [DATA_W-1:0] sivl_d [ENTRIES];
  logic [DATA_W-1:0] stmo_q [ENTRIES];
  logic [DATA_W-1:0] stmo_d [ENTRIES];
  logic [DATA_W-1:0] stpp_q [ENTRIES];
  logic [DATA_W-1:0] stpp_d [ENTRIES];
  logic [DATA_W-1:0] scnt_q [ENTRIES];
  logic [DATA_W-1:0] scnt_d [ENTRIES];
  phase_e            sph_q [ENTRIES];
  phase_e            sph_d [ENTRIES];
  logic [DATA_W-1:0] tick_q, tick_d;
  logic [DATA_W-1:0] next_id_q, next_id_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d, last_idx_q, last_idx_d;
  logic [DATA_W-1:0] best_id_q, best_id_d, last_id_q, last_id_d;
  logic              found_q, found_d, have_last_q, have_last_d;
  logic              lower_q, lower_d, chk_empty_q, chk_empty_d;
  cmd_e              cmd_q, cmd_d;
  logic [DATA_W-1:0] key_q, key_d, ivl_q, ivl_d, tmo_q, tmo_d, ref_q, ref_d;
  logic              alive_q, alive_d;
  res_t              res_q, res_d, out_q, out_d;
  logic              out_vld_q, out_vld_d;
  logic              out_free, at_end, cand;
  logic [IDX_W-1:0]  free_idx;
  logic              free_ok;
  logic [DATA_W-1:0] cnt_new;
  phase_e            ph_new;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  hbwd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free = !out_vld_q || m_axis_tready;
  assign at_end = (idx_q == IDX_W'(ENTRIES - 1));
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = {5'b0, out_q.loc, out_q.id, out_q.status};
  assign m_axis_tuser = out_q.kind;
  assign m_axis_tlast = out_q.last;

  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_ok = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    valid_d = valid_q;
    sid_d = sid_q;
    sloc_d = sloc_q;
    sivl_d = sivl_q;
    stmo_d = stmo_q;
    stpp_d = stpp_q;
    scnt_d = scnt_q;
    sph_d = sph_q;
    tick_d = tick_q;
    next_id_d = next_id_q;
    idx_d = idx_q;
    best_idx_d = best_idx_q;
    best_id_d = best_id_q;
    last_idx_d = last_idx_q;
    last_id_d = last_id_q;
    found_d = found_q;
    have_last_d = have_last_q;
    lower_d = lower_q;
    chk_empty_d = chk_empty_q;
    cmd_d = cmd_q;
    key_d = key_q;
    ivl_d = ivl_q;
    tmo_d = tmo_q;
    ref_d = ref_q;
    alive_d = alive_q;
    res_d = res_q;
    out_d = out_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    div_req.start = 1'b0;
    div_req.dividend = sivl_q[idx_q];
    div_req.divisor = tick_q;
    cand = 1'b0;
    cnt_new = scnt_q[best_idx_q];
    ph_new = sph_q[best_idx_q];

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = cmd_e'(s_axis_tuser);
          key_d = s_axis_tdata[63:32];
          ivl_d = s_axis_tdata[95:64];
          tmo_d = s_axis_tdata[127:96];
          ref_d = s_axis_tdata[159:128];
          alive_d = s_axis_tdata[160];
          idx_d = '0;
          found_d = 1'b0;
          have_last_d = 1'b0;
          chk_empty_d = 1'b0;
          ret_d = S_IDLE;
          state_d = S_EMIT;
          case (cmd_e'(s_axis_tuser))
            CMD_TICK:  state_d = S_TK_SCAN;
            CMD_START: begin
              if (s_axis_tdata[31:0] != local_host_q) begin
                res_d = mk_res(KIND_DONE, ST_BAD_LOC, '0, s_axis_tdata[63:32], 1'b1);
              end else begin
                state_d = S_SA_LOC;
              end
            end
            CMD_STOP:  state_d = S_FIND;
            CMD_REPLY: state_d = S_FIND;
            CMD_SET: begin
              if (s_axis_tdata[95:64] == '0) begin
                res_d = mk_res(KIND_DONE, ST_BAD_IVL, '0, '0, 1'b1);
              end else begin
                state_d = S_SET_SCAN;
              end
            end
            default: res_d = mk_res(KIND_DONE, ST_OK, '0, '0, 1'b1);
          endcase
        end
      end

      S_TK_SCAN: begin
        cand = valid_q[idx_q] &&
               (!have_last_q || sid_q[idx_q] > last_id_q ||
                (sid_q[idx_q] == last_id_q && idx_q > last_idx_q)) &&
               (!found_q || sid_q[idx_q] < best_id_q);
        if (cand) begin
          found_d = 1'b1;
          best_idx_d = idx_q;
          best_id_d = sid_q[idx_q];
        end
        idx_d = idx_q + 1'b1;
        if (at_end) begin
          idx_d = '0;
          state_d = (cand || found_q) ? S_TK_PROC : S_TK_END;
        end
      end

      S_TK_PROC: begin
        if (sph_q[best_idx_q] == PH_INIT) begin
          ph_new = PH_WAIT;
        end else if (scnt_q[best_idx_q] != INTERVAL_MAX) begin
          cnt_new = scnt_q[best_idx_q] + 1'b1;
        end
        sph_d[best_idx_q] = ph_new;
        scnt_d[best_idx_q] = cnt_new;
        have_last_d = 1'b1;
        last_idx_d = best_idx_q;
        last_id_d = best_id_q;
        found_d = 1'b0;
        state_d = S_TK_SCAN;
        if (cnt_new >= stpp_q[best_idx_q]) begin
          if (ph_new == PH_OK) begin
            sph_d[best_idx_q] = PH_WAIT;
            res_d = mk_res(KIND_POLL, ST_OK, best_id_q, sloc_q[best_idx_q], 1'b0);
            ret_d = S_TK_SCAN;
            state_d = S_EMIT;
          end else if (ph_new == PH_WAIT) begin
            valid_d[best_idx_q] = 1'b0;
            res_d = mk_res(KIND_FAIL, ST_OK, best_id_q, sloc_q[best_idx_q], 1'b0);
            ret_d = S_TK_SCAN;
            state_d = S_EMIT;
          end
        end
      end

      S_TK_END: begin
        if (valid_q == '0) begin
          tick_d = INTERVAL_MAX;
        end
        res_d = mk_res(KIND_DONE, ST_OK, '0, '0, 1'b1);
        ret_d = S_IDLE;
        state_d = S_EMIT;
      end

      S_SA_LOC: begin
        idx_d = idx_q + 1'b1;
        if (valid_q[idx_q] && sloc_q[idx_q] == key_q) begin
          res_d = mk_res(KIND_DONE, ST_OK, next_id_q, key_q, 1'b1);
          state_d = S_EMIT;
        end else if (at_end) begin
          idx_d = '0;
          lower_d = ivl_q < tick_q;
          if (tmo_q >= ivl_q) begin
            res_d = mk_res(KIND_DONE, ST_BAD_TMO, '0, key_q, 1'b1);
            state_d = S_EMIT;
          end else begin
            state_d = (ivl_q < tick_q) ? S_SA_DIV_GO : S_SA_COMMIT;
          end
        end
      end

      S_SA_DIV_GO: begin
        div_req.divisor = ivl_q;
        if (valid_q[idx_q]) begin
          div_req.start = 1'b1;
          state_d = S_SA_DIV_WAIT;
        end else begin
          idx_d = idx_q + 1'b1;
          if (at_end) begin
            idx_d = '0;
            state_d = S_SA_COMMIT;
          end
        end
      end

      S_SA_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (stmo_q[idx_q] >= sivl_q[idx_q] - div_rsp.rem) begin
            res_d = mk_res(KIND_DONE, ST_BAD_IVL, '0, key_q, 1'b1);
            state_d = S_EMIT;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = S_SA_DIV_GO;
            if (at_end) begin
              idx_d = '0;
              state_d = S_SA_COMMIT;
            end
          end
        end
      end

      S_SA_COMMIT: begin
        if (!free_ok) begin
          res_d = mk_res(KIND_DONE, ST_FULL, '0, key_q, 1'b1);
          state_d = S_EMIT;
        end else begin
          if (lower_q) begin
            tick_d = ivl_q;
          end
          next_id_d = next_id_q + 1'b1;
          valid_d[free_idx] = 1'b1;
          sid_d[free_idx] = next_id_q + 1'b1;
          sloc_d[free_idx] = key_q;
          sivl_d[free_idx] = ivl_q;
          stmo_d[free_idx] = tmo_q;
          scnt_d[free_idx] = '0;
          sph_d[free_idx] = PH_INIT;
          idx_d = '0;
          state_d = S_RT_GO;
        end
      end

      S_SA_FIN: begin
        res_d = mk_res(KIND_DONE, ST_OK, next_id_q, key_q, 1'b1);
        ret_d = S_IDLE;
        state_d = S_EMIT;
      end

      S_RT_GO: begin
        if (valid_q[idx_q]) begin
          div_req.start = 1'b1;
          state_d = S_RT_WAIT;
        end else begin
          idx_d = idx_q + 1'b1;
          if (at_end) begin
            idx_d = '0;
            state_d = S_RT_END;
          end
        end
      end

      S_RT_WAIT: begin
        if (div_rsp.done) begin
          stpp_d[idx_q] = div_rsp.quo;
          idx_d = idx_q + 1'b1;
          state_d = S_RT_GO;
          if (at_end) begin
            idx_d = '0;
            state_d = S_RT_END;
          end
        end
      end

      S_RT_END: begin
        state_d = S_EMIT;
        if (cmd_q == CMD_START) begin
          res_d = mk_res(KIND_POLL, ST_OK, next_id_q, key_q, 1'b0);
          ret_d = S_SA_FIN;
        end else begin
          res_d = mk_res(KIND_DONE, ST_OK, '0, '0, 1'b1);
          ret_d = S_IDLE;
        end
      end

      S_SET_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (valid_q[idx_q] && (sivl_q[idx_q] < ivl_q || stmo_q[idx_q] >= ivl_q)) begin
          res_d = mk_res(KIND_DONE, ST_BAD_IVL, '0, '0, 1'b1);
          state_d = S_EMIT;
        end else if (at_end) begin
          idx_d = '0;
          tick_d = ivl_q;
          state_d = S_RT_GO;
        end
      end

      S_FIND: begin
        if (valid_q[idx_q] && sid_q[idx_q] == ref_q) begin
          state_d = S_EMIT;
          res_d = mk_res(KIND_DONE, ST_OK, ref_q, sloc_q[idx_q], 1'b1);
          if (cmd_q == CMD_STOP) begin
            valid_d[idx_q] = 1'b0;
            chk_empty_d = 1'b1;
          end else if (alive_q) begin
            scnt_d[idx_q] = '0;
            sph_d[idx_q] = PH_OK;
          end else begin
            valid_d[idx_q] = 1'b0;
            chk_empty_d = 1'b1;
            res_d = mk_res(KIND_FAIL, ST_OK, ref_q, sloc_q[idx_q], 1'b0);
            ret_d = S_RP_FIN;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          if (at_end) begin
            res_d = mk_res(KIND_DONE, ST_BAD_ID, ref_q, '0, 1'b1);
            state_d = S_EMIT;
          end
        end
      end

      S_RP_FIN: begin
        res_d = mk_res(KIND_DONE, ST_OK, ref_q, sloc_q[idx_q], 1'b1);
        ret_d = S_IDLE;
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_d = res_q;
          out_vld_d = 1'b1;
          state_d = ret_q;
          if (ret_q == S_IDLE && chk_empty_q && valid_q == '0) begin
            tick_d = INTERVAL_MAX;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= S_IDLE;
      local_host_q <= '0;
      valid_q <= '0;
      tick_q <= INTERVAL_MAX;
      next_id_q <= '0;
      idx_q <= '0;
      found_q <= 1'b0;
      have_last_q <= 1'b0;
      lower_q <= 1'b0;
      chk_empty_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      if (cfg_valid) begin
        local_host_q <= cfg_data;
      end
      valid_q <= valid_d;
      tick_q <= tick_d;
      next_id_q <= next_id_d;
      idx_q <= idx_d;
      found_q <= found_d;
      have_last_q <= have_last_d;
      lower_q <= lower_d;
      chk_empty_q <= chk_empty_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sid_q <= sid_d;
    sloc_q <= sloc_d;
    sivl_q <= sivl_d;
    stmo_q <= stmo_d;
    stpp_q <= stpp_d;
    scnt_q <= scnt_d;
    sph_q <= sph_d;
    best_idx_q <= best_idx_d;
    best_id_q <= best_id_d;
    last_idx_q <= last_idx_d;
    last_id_q <= last_id_d;
    cmd_q <= cmd_d;
    key_q <= key_d;
    ivl_q <= ivl_d;
    tmo_q <= tmo_d;
    ref_q <= ref_d;
    alive_q <= alive_d;
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule

/* sv/hbwd_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on hbwd_pkg for widths and the request/response structs.
module hbwd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hbwd_pkg::div_req_t req_i,
  output hbwd_pkg::div_rsp_t rsp_o
);
  import hbwd_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] den_q, den_d;
  logic [DATA_W:0]   trial;
  logic              fits;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    trial = {rem_q, quo_q[DATA_W-1]};
    fits = trial >= {1'b0, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d = '0;
      quo_d = req_i.dividend;
      rem_d = '0;
      den_d = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? DATA_W'(trial - {1'b0, den_q}) : trial[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo = quo_q;
  assign rsp_o.rem = rem_q;

endmodule

/* verif/tb_top.sv */
// Testbench for heartbeat_watchdog_table: drives command beats and local_host
// writes, predicts result beats with a scoreboard class. Depends on hbwd_pkg.
import hbwd_pkg::*;

typedef struct {
  kind_e             kind;
  status_e           status;
  logic [31:0]       id;
  logic [31:0]       loc;
  logic              last;
} beat_t;

class watchdog_scoreboard;
  logic [31:0] host_reg;
  bit          valid_q [16];
  logic [31:0] id_q [16];
  logic [31:0] loc_q [16];
  logic [31:0] ivl_q [16];
  logic [31:0] tmo_q [16];
  logic [31:0] tpp_q [16];
  logic [31:0] cnt_q [16];
  phase_e      ph_q [16];
  logic [31:0] tick_ivl;
  logic [31:0] id_ctr;
  beat_t       pending[$];
  int          errors;

  function new();
    host_reg = 0;
    tick_ivl = INTERVAL_MAX;
    id_ctr = 0;
    errors = 0;
    foreach (valid_q[i]) valid_q[i] = 0;
  endfunction

  function void push(kind_e k, status_e s, logic [31:0] id, logic [31:0] loc, logic l);
    beat_t b;
    b.kind = k; b.status = s; b.id = id; b.loc = loc; b.last = l;
    pending.push_back(b);
  endfunction

  function bit empty_table();
    foreach (valid_q[i]) if (valid_q[i]) return 0;
    return 1;
  endfunction

  function int find_entry(logic [31:0] id);
    for (int i = 0; i < 16; i++) if (valid_q[i] && id_q[i] == id) return i;
    return -1;
  endfunction

  function void retune();
    foreach (valid_q[i]) if (valid_q[i]) tpp_q[i] = ivl_q[i] / tick_ivl;
  endfunction

  function void tick();
    int order[$];
    int i, j;
    for (i = 0; i < 16; i++) begin
      if (!valid_q[i]) continue;
      j = order.size();
      while (j > 0 && id_q[order[j-1]] > id_q[i]) j--;
      order.insert(j, i);
    end
    foreach (order[k]) begin
      i = order[k];
      if (ph_q[i] == PH_INIT) ph_q[i] = PH_WAIT;
      else if (cnt_q[i] != 32'hFFFF_FFFF) cnt_q[i]++;
      if (ph_q[i] == PH_OK) begin
        if (cnt_q[i] >= tpp_q[i]) begin
          ph_q[i] = PH_WAIT;
          push(KIND_POLL, ST_OK, id_q[i], loc_q[i], 0);
        end
      end else if (ph_q[i] == PH_WAIT && cnt_q[i] >= tpp_q[i]) begin
        push(KIND_FAIL, ST_OK, id_q[i], loc_q[i], 0);
        valid_q[i] = 0;
      end
    end
    if (empty_table()) tick_ivl = INTERVAL_MAX;
    push(KIND_DONE, ST_OK, 0, 0, 1);
  endfunction

  function void start(logic [31:0] host, logic [31:0] key, logic [31:0] ivl,
                      logic [31:0] tmo);
    logic [31:0] nt;
    int fs;
    nt = tick_ivl;
    fs = -1;
    if (host != host_reg) begin push(KIND_DONE, ST_BAD_LOC, 0, key, 1); return; end
    foreach (valid_q[i])
      if (valid_q[i] && loc_q[i] == key) begin push(KIND_DONE, ST_OK, id_ctr, key, 1); return; end
    if (tmo >= ivl) begin push(KIND_DONE, ST_BAD_TMO, 0, key, 1); return; end
    if (ivl < tick_ivl) begin
      foreach (valid_q[i])
        if (valid_q[i] && {32'd0, tmo_q[i]} >= 64'(ivl) * 64'(ivl_q[i] / ivl)) begin
          push(KIND_DONE, ST_BAD_IVL, 0, key, 1); return;
        end
      nt = ivl;
    end
    for (int i = 15; i >= 0; i--) if (!valid_q[i]) fs = i;
    if (fs < 0) begin push(KIND_DONE, ST_FULL, 0, key, 1); return; end
    tick_ivl = nt;
    retune();
    id_ctr++;
    valid_q[fs] = 1; id_q[fs] = id_ctr; loc_q[fs] = key; ivl_q[fs] = ivl;
    tmo_q[fs] = tmo; tpp_q[fs] = ivl / tick_ivl; cnt_q[fs] = 0; ph_q[fs] = PH_INIT;
    push(KIND_POLL, ST_OK, id_ctr, key, 0);
    push(KIND_DONE, ST_OK, id_ctr, key, 1);
  endfunction

  function void note_command(logic [2:0] cmd, logic [31:0] host, logic [31:0] key,
                             logic [31:0] ivl, logic [31:0] tmo, logic [31:0] ref_id,
                             logic alive);
    int s;
    logic [31:0] l;
    case (cmd)
      CMD_TICK: tick();
      CMD_START: start(host, key, ivl, tmo);
      CMD_STOP: begin
        s = find_entry(ref_id);
        if (s < 0) push(KIND_DONE, ST_BAD_ID, ref_id, 0, 1);
        else begin
          l = loc_q[s];
          valid_q[s] = 0;
          if (empty_table()) tick_ivl = INTERVAL_MAX;
          push(KIND_DONE, ST_OK, ref_id, l, 1);
        end
      end
      CMD_SET: begin
        bit bad;
        bad = (ivl == 0);
        foreach (valid_q[i]) if (valid_q[i] && (ivl_q[i] < ivl || tmo_q[i] >= ivl)) bad = 1;
        if (bad) push(KIND_DONE, ST_BAD_IVL, 0, 0, 1);
        else begin
          tick_ivl = ivl;
          retune();
          push(KIND_DONE, ST_OK, 0, 0, 1);
        end
      end
      CMD_REPLY: begin
        s = find_entry(ref_id);
        if (s < 0) push(KIND_DONE, ST_BAD_ID, ref_id, 0, 1);
        else if (alive) begin
          cnt_q[s] = 0; ph_q[s] = PH_OK;
          push(KIND_DONE, ST_OK, ref_id, loc_q[s], 1);
        end else begin
          l = loc_q[s];
          push(KIND_FAIL, ST_OK, ref_id, l, 0);
          valid_q[s] = 0;
          if (empty_table()) tick_ivl = INTERVAL_MAX;
          push(KIND_DONE, ST_OK, ref_id, l, 1);
        end
      end
      default: push(KIND_DONE, ST_OK, 0, 0, 1);
    endcase
  endfunction

  function void check_beat(logic [1:0] k, logic [2:0] s, logic [31:0] id, logic [31:0] loc,
                           logic l);
    beat_t e;
    if (pending.size() == 0) begin
      report_mismatch($sformatf("unexpected beat kind %0d id %0h", k, id));
      return;
    end
    e = pending.pop_front();
    if (k !== e.kind || s !== e.status || id !== e.id || loc !== e.loc || l !== e.last)
      report_mismatch($sformatf("got k%0d s%0d id %0h loc %0h l%0b, want k%0d s%0d id %0h loc %0h l%0b",
        k, s, id, loc, l, e.kind, e.status, e.id, e.loc, e.last));
  endfunction

  function void report_mismatch(string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endfunction
endclass

module tb_top;
  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [31:0] cfg_data = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  // host, location_key, interval, reply_timeout, entry_ref, alive, pad
  logic [IN_W-1:0] s_axis_tdata = '0;
  // cmd
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  // status, result_id, result_location, pad
  logic [OUT_W-1:0] m_axis_tdata;
  // kind
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  watchdog_scoreboard sb = new();
  logic [31:0] keys [8];
  int idle_cycles = 0;
  bit hold_off = 0;
  bit finished = 0;
  int burst_left = 0;

  heartbeat_watchdog_table u_top (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 7) == 0);
    if (m_axis_tvalid && m_axis_tready)
      sb.check_beat(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[66:35],
                    m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !finished) begin
      $display("heartbeat_watchdog_table verification failed");
      $finish;
    end
  end

  task automatic write_host(logic [31:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    sb.host_reg = v;
    cfg_valid <= 0;
  endtask

  task automatic send(logic [2:0] cmd, logic [31:0] host, logic [31:0] key, logic [31:0] ivl,
                      logic [31:0] tmo, logic [31:0] ref_id, logic alive);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {7'd0, alive, ref_id, tmo, ivl, key, host};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, host, key, ivl, tmo, ref_id, alive);
    if (burst_left == 0) s_axis_tvalid <= 0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic random_item();
    int r;
    logic [31:0] ivl;
    r = $urandom_range(0, 99);
    ivl = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 40);
    if (r < 30)
      send(CMD_TICK, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           1'($urandom()));
    else if (r < 55)
      send(CMD_START, $urandom_range(0, 9) == 0 ? $urandom() : sb.host_reg,
           keys[$urandom_range(0, 7)], ivl, $urandom_range(0, ivl), 0, 0);
    else if (r < 62)
      send(CMD_STOP, 0, 0, 0, 0, sb.id_ctr - $urandom_range(0, 12), 0);
    else if (r < 72)
      send(CMD_SET, 0, 0, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 20), 0,
           0, 0);
    else if (r < 97)
      send(CMD_REPLY, 0, 0, 0, 0, sb.id_ctr - $urandom_range(0, 10),
           $urandom_range(0, 4) != 0);
    else send(3'($urandom_range(5, 7)), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), 1'($urandom()));
  endtask

  initial begin
    foreach (keys[i]) keys[i] = $urandom();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    write_host(32'hFFFF_FFFF);
    send(CMD_TICK, 0, 0, 0, 0, 0, 0);
    send(CMD_START, 0, keys[0], 10, 2, 0, 0);
    send(CMD_START, 32'hFFFF_FFFF, keys[0], 10, 10, 0, 0);
    send(CMD_START, 32'hFFFF_FFFF, keys[0], 32'hFFFF_FFFF, 32'hFFFF_FFFE, 0, 0);
    send(CMD_START, 32'hFFFF_FFFF, keys[0], 5, 1, 0, 0);
    send(CMD_START, 32'hFFFF_FFFF, keys[1], 3, 2, 0, 0);
    send(CMD_START, 32'hFFFF_FFFF, keys[2], 0, 0, 0, 0);
    send(CMD_SET, 0, 0, 0, 0, 0, 0);
    send(CMD_SET, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send(CMD_SET, 0, 0, 3, 0, 0, 0);
    send(CMD_TICK, 0, 0, 0, 0, 0, 0);
    send(CMD_REPLY, 0, 0, 0, 0, 1, 1);
    send(CMD_REPLY, 0, 0, 0, 0, 32'hFFFF_FFFF, 1);
    send(CMD_TICK, 0, 0, 0, 0, 0, 0);
    send(CMD_REPLY, 0, 0, 0, 0, 2, 0);
    send(CMD_STOP, 0, 0, 0, 0, 1, 0);
    send(CMD_STOP, 0, 0, 0, 0, 1, 0);
    send(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    for (int i = 0; i < 17; i++)
      send(CMD_START, 32'hFFFF_FFFF, 32'h100 + i, 100, 50, 0, 0);
    drain();
    write_host(0);
    for (int i = 0; i < 16; i++) send(CMD_STOP, 0, 0, 0, 0, sb.id_ctr - i, 0);
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      for (int i = 0; i < 30; i++) random_item();
    join
    drain();
    write_host($urandom());
    for (int i = 0; i < 25; i++) random_item();
    drain();
    write_host(32'h0);
    for (int i = 0; i < 24; i++) random_item();
    drain();
    finished = 1;
    if (sb.errors == 0) $display("heartbeat_watchdog_table verification clean");
    else $display("heartbeat_watchdog_table verification failed");
    $finish;
  end
endmodule
